// ===== sv/dsnt_pkg.sv =====
// Package for the depressing synapse network tick core.
// Holds shared constants and the controller-to-datapath command struct.
`default_nettype none
package dsnt_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_UNITS = 9;
    localparam int ORTH0     = 5;
    localparam int SEM0      = 7;

    localparam logic [2:0] REG_LEAK    = 3'd0;
    localparam logic [2:0] REG_DEPL    = 3'd1;
    localparam logic [2:0] REG_RECOV   = 3'd2;
    localparam logic [2:0] REG_INHIB   = 3'd3;
    localparam logic [2:0] REG_THRESH  = 3'd4;
    localparam logic [2:0] REG_FEEDBK  = 3'd5;
    localparam logic [2:0] REG_RATES   = 3'd6;
    localparam logic [2:0] REG_PRIMEW  = 3'd7;

    typedef struct packed {
        logic       load;
        logic       out_en;
        logic [3:0] out_idx;
        logic       upd_en;
        logic [3:0] upd_idx;
        logic [2:0] upd_phase;
        logic       finish;
    } dsnt_cmd_t;
endpackage
`default_nettype wire

// ===== sv/depressing_synapse_network_tick_core.sv =====
// Usage: each s_ transaction is one 1 ms network tick. s_tdata carries the
// five 17-bit visual drives and choice_time, s_tuser the flags; the block
// returns one m_ transaction per tick: both semantic outputs, peak times.
// After the load, the block computes the nine unit outputs, then updates
// nine units through six steps each using the shared multiplier, then commits.
// One tick is in work at a time; the result sits in an output register, a
// new tick is accepted while it waits, and the next result is held back
// until the receiver takes the previous one. Reset (aresetn low, synchronous)
// restores register defaults and unit state. Configuration writes go through
// cfg_we, cfg_addr and cfg_wdata; the user must make them only while idle,
// as the block does not enforce it.
// Depends on dsnt_pkg, dsnt_ctrl and dsnt_dp.
`default_nettype none
module depressing_synapse_network_tick_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // drive_prime, drive_target, drive_mask, drive_target_choice,
    // drive_foil_choice (17b each), choice_time (16b), zero pad
    input  wire logic [103:0] s_tdata,
    // check_peak, restart
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // target_activation, foil_activation (17b), target_peak_time,
    // foil_peak_time (16b), zero pad
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [47:0] cfg_wdata
);
    import dsnt_pkg::*;

    logic [15:0] leak_reg, depl_reg, recov_reg, inhib_reg, thresh_reg, fb_gain_reg;
    logic [47:0] rates_reg;
    logic [31:0] primew_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leak_reg    <= 16'd9830;
            depl_reg    <= 16'd21234;
            recov_reg   <= 16'd1442;
            inhib_reg   <= 16'd64512;
            thresh_reg  <= 16'd9830;
            fb_gain_reg <= 16'd16384;
            rates_reg   <= 48'd4222214408071;
            primew_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LEAK:   leak_reg    <= cfg_wdata[15:0];
                REG_DEPL:   depl_reg    <= cfg_wdata[15:0];
                REG_RECOV:  recov_reg   <= cfg_wdata[15:0];
                REG_INHIB:  inhib_reg   <= cfg_wdata[15:0];
                REG_THRESH: thresh_reg  <= cfg_wdata[15:0];
                REG_FEEDBK: fb_gain_reg <= cfg_wdata[15:0];
                REG_RATES:  rates_reg   <= cfg_wdata;
                REG_PRIMEW: primew_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    dsnt_cmd_t   cmd;
    logic        idle;
    logic [16:0] so0, so1;
    logic [15:0] pk0, pk1;
    logic        mvalid_reg;
    logic [71:0] mdata_reg;

    assign s_tready = idle;

    dsnt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid),
        .out_busy (mvalid_reg && !m_tready),
        .idle     (idle),
        .cmd      (cmd)
    );

    dsnt_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .drives          (s_tdata[84:0]),
        .check_peak      (s_tuser[0]),
        .choice_time     (s_tdata[100:85]),
        .restart         (s_tuser[1]),
        .leak_rate       (leak_reg),
        .depletion_rate  (depl_reg),
        .recovery_rate   (recov_reg),
        .inhibition_gain (inhib_reg),
        .fire_threshold  (thresh_reg),
        .feedback_gain   (fb_gain_reg),
        .layer_rates     (rates_reg),
        .prime_weights   (primew_reg),
        .sem_out0        (so0),
        .sem_out1        (so1),
        .peak0           (pk0),
        .peak1           (pk1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (cmd.finish) mdata_reg <= {6'd0, pk1, pk0, so1, so0};
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
endmodule
`default_nettype wire

// ===== sv/dsnt_ctrl.sv =====
// Controller state machine for the network tick core.
// Sequences output computation and unit updates; depends on dsnt_pkg.
`default_nettype none
module dsnt_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic            out_busy,
    output logic                 idle,
    output dsnt_pkg::dsnt_cmd_t  cmd
);
    import dsnt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_OUT  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DONE = 5'b01000,
        ST_WAIT = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] ph_reg, ph_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        idle       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
            end
            ST_OUT: begin
                cmd.out_en  = 1'b1;
                cmd.out_idx = idx_reg;
                if (idx_reg == 4'(NUM_UNITS - 1)) begin
                    idx_next   = '0;
                    ph_next    = '0;
                    state_next = ST_UPD;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_UPD: begin
                cmd.upd_en    = 1'b1;
                cmd.upd_idx   = idx_reg;
                cmd.upd_phase = ph_reg;
                if (ph_reg == 3'd5) begin
                    ph_next = '0;
                    if (idx_reg == 4'(NUM_UNITS - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end else begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_DONE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/dsnt_dp.sv =====
// Datapath for the network tick core: unit state, a shared multiplier beside dedicated ones.
// Driven by commands from dsnt_ctrl; depends on dsnt_pkg.
`default_nettype none
module dsnt_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dsnt_pkg::dsnt_cmd_t    cmd,
    input  wire logic [5*17-1:0]        drives,
    input  wire logic                   check_peak,
    input  wire logic [15:0]            choice_time,
    input  wire logic                   restart,
    input  wire logic [15:0]            leak_rate,
    input  wire logic [15:0]            depletion_rate,
    input  wire logic [15:0]            recovery_rate,
    input  wire logic [15:0]            inhibition_gain,
    input  wire logic [15:0]            fire_threshold,
    input  wire logic [15:0]            feedback_gain,
    input  wire logic [47:0]            layer_rates,
    input  wire logic [31:0]            prime_weights,
    output logic [16:0]                 sem_out0,
    output logic [16:0]                 sem_out1,
    output logic [15:0]                 peak0,
    output logic [15:0]                 peak1
);
    import dsnt_pkg::*;

    localparam int VW = FRAC_BITS + 1;
    localparam int SW = VW + 4;
    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

    logic [VW-1:0] mem_reg [NUM_UNITS];
    logic [VW-1:0] amp_reg [NUM_UNITS];
    logic [VW-1:0] outv_reg [NUM_UNITS];
    logic [VW-1:0] fb_reg [2];
    logic [VW-1:0] prev_reg [2];
    logic [15:0]   peak_reg [2];
    logic [VW-1:0] vin_reg [5];
    logic          chk_reg;
    logic [15:0]   ctime_reg;

    logic signed [SW+1:0] p_reg, q_reg, inp_reg, inh_reg;
    logic signed [SW+1:0] p_next, q_next, inp_next, inh_next;

    function automatic logic [VW-1:0] sat_one(input logic [16:0] d);
        logic [VW+16:0] w;
        begin
            w = (VW+17)'(d);
            sat_one = (w > (VW+17)'(ONE)) ? ONE : VW'(w);
        end
    endfunction

    function automatic logic [VW-1:0] clamp01(input logic signed [SW+1:0] v);
        begin
            if (v < 0) clamp01 = '0;
            else if (v > (SW+2)'(ONE)) clamp01 = ONE;
            else clamp01 = VW'(v);
        end
    endfunction

    // Shared multiplier: unsigned operand (up to SW bits) times a VW-bit factor.
    logic [SW-1:0]    ma;
    logic [VW-1:0]    mb;
    logic [SW+VW-1:0] mprod;
    logic [SW-1:0]    mq;
    assign mprod = ma * mb;
    assign mq    = SW'(mprod >> FRAC_BITS);

    logic [VW-1:0] cur_m, cur_a, above;
    logic [1:0]    layer;
    logic [15:0]   srate;
    logic [15:0]   wt, wf;
    logic          uidx0;
    logic [3:0]    ui;
    logic [SW+1:0] pabs;
    logic          pneg;

    assign ui    = cmd.out_en ? cmd.out_idx : cmd.upd_idx;
    assign cur_m = mem_reg[ui];
    assign cur_a = amp_reg[ui];
    assign above = (cur_m > VW'(fire_threshold)) ? cur_m - VW'(fire_threshold) : '0;
    assign layer = (ui < 4'(ORTH0)) ? 2'd0 : (ui < 4'(SEM0)) ? 2'd1 : 2'd2;
    assign srate = (layer == 2'd0) ? layer_rates[15:0]
                 : (layer == 2'd1) ? layer_rates[31:16] : layer_rates[47:32];
    assign wt    = prime_weights[15:0];
    assign wf    = prime_weights[31:16];
    assign uidx0 = (layer == 2'd1) ? (ui == 4'(ORTH0)) : (ui == 4'(SEM0));
    assign pneg  = p_reg < 0;
    assign pabs  = pneg ? (SW+2)'(-p_reg) : (SW+2)'(p_reg);

    // Inhibition and input sums computed from stored outputs.
    logic [SW-1:0] vis_inh, orth_inh, sem_inh, orth_base;
    always_comb begin
        vis_inh  = SW'(outv_reg[0]) + SW'(outv_reg[1]) + SW'(outv_reg[2]);
        orth_inh = SW'(outv_reg[ORTH0]) + SW'(outv_reg[ORTH0+1]);
        sem_inh  = SW'(outv_reg[SEM0]) + SW'(outv_reg[SEM0+1]);
        orth_base = uidx0 ? SW'(outv_reg[1]) + SW'(outv_reg[3]) : SW'(outv_reg[4]);
    end

    always_comb begin
        ma = '0;
        mb = '0;
        p_next = p_reg;
        q_next = q_reg;
        inp_next = inp_reg;
        inh_next = inh_reg;
        if (cmd.out_en) begin
            ma = SW'(above);
            mb = cur_a;
        end else if (cmd.upd_en) begin
            unique case (cmd.upd_phase)
                3'd0: begin
                    if (layer == 2'd1) begin
                        ma = SW'(outv_reg[0]);
                        mb = VW'(uidx0 ? wt : wf);
                        inp_next = (SW+2)'(SW'(mprod >> 14)) + (SW+2)'(orth_base);
                    end else if (layer == 2'd2) begin
                        inp_next = (SW+2)'(outv_reg[ui - 4'd2]);
                    end else begin
                        inp_next = (SW+2)'(vin_reg[ui[2:0]]);
                    end
                    inh_next = (layer == 2'd0)
                        ? ((ui < 4'd3) ? (SW+2)'(vis_inh) : (SW+2)'(outv_reg[ui]))
                        : (layer == 2'd1) ? (SW+2)'(orth_inh) : (SW+2)'(sem_inh);
                end
                3'd1: begin
                    if (layer == 2'd1) begin
                        ma = SW'(fb_reg[uidx0 ? 0 : 1]);
                        mb = VW'(feedback_gain);
                        inp_next = inp_reg + (SW+2)'(mq);
                    end
                    p_next = -((SW+2)'(cur_m) * 0) - (SW+2)'(SW'((
                        (SW+FRAC_BITS)'(cur_m) * (SW+FRAC_BITS)'(leak_rate)) >> FRAC_BITS));
                end
                3'd2: begin
                    ma = SW'(inp_reg);
                    mb = ONE - cur_m;
                    if (cur_m == '0) begin
                        p_next = p_reg + inp_reg;
                    end else begin
                        p_next = p_reg + (SW+2)'(mq);
                    end
                    inh_next = (SW+2)'(SW'(((SW+VW)'(inh_reg) * (SW+VW)'(cur_m))
                                >> FRAC_BITS));
                end
                3'd3: begin
                    ma = SW'(inh_reg);
                    mb = VW'(inhibition_gain);
                    p_next = p_reg - (SW+2)'(mq);
                    q_next = (SW+2)'(SW'(((SW+16)'(ONE - cur_a) * (SW+16)'(recovery_rate))
                              >> FRAC_BITS));
                end
                3'd4: begin
                    ma = SW'(outv_reg[ui]);
                    mb = VW'(depletion_rate);
                    q_next = q_reg - (SW+2)'(mq);
                end
                3'd5: begin
                    ma = SW'(pabs);
                    mb = VW'(srate);
                end
                default: ;
            endcase
        end
    end

    logic [SW+1:0] qabs;
    logic [SW+17:0] qprod;
    logic signed [SW+1:0] mstep, astep;
    assign qabs  = (q_reg < 0) ? (SW+2)'(-q_reg) : (SW+2)'(q_reg);
    assign qprod = (SW+18)'(qabs) * (SW+18)'(srate);
    assign mstep = pneg ? -(SW+2)'(mq) : (SW+2)'(mq);
    assign astep = (q_reg < 0) ? -(SW+2)'(qprod >> FRAC_BITS)
                               : (SW+2)'(qprod >> FRAC_BITS);

    logic [VW-1:0] so0, so1;
    assign so0 = outv_reg[SEM0];
    assign so1 = outv_reg[SEM0+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                mem_reg[i] <= '0;
                amp_reg[i] <= ONE;
            end
            for (int i = 0; i < 2; i++) begin
                fb_reg[i]   <= '0;
                prev_reg[i] <= '0;
                peak_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                for (int i = 0; i < 5; i++) vin_reg[i] <= sat_one(drives[i*17 +: 17]);
                chk_reg   <= check_peak;
                ctime_reg <= choice_time;
                if (restart) begin
                    for (int i = 0; i < NUM_UNITS; i++) begin
                        mem_reg[i] <= '0;
                        amp_reg[i] <= ONE;
                    end
                    for (int i = 0; i < 2; i++) begin
                        fb_reg[i]   <= '0;
                        prev_reg[i] <= '0;
                        peak_reg[i] <= '0;
                    end
                end
            end
            if (cmd.out_en) outv_reg[ui] <= VW'(mq);
            if (cmd.upd_en && cmd.upd_phase == 3'd5) begin
                mem_reg[ui] <= clamp01((SW+2)'(cur_m) + mstep);
                amp_reg[ui] <= clamp01((SW+2)'(cur_a) + astep);
                if (ui == 4'(NUM_UNITS - 1)) begin
                    fb_reg[0] <= so0;
                    fb_reg[1] <= so1;
                    if (chk_reg) begin
                        if (so0 < prev_reg[0] && peak_reg[0] == '0) peak_reg[0] <= ctime_reg;
                        if (so1 < prev_reg[1] && peak_reg[1] == '0) peak_reg[1] <= ctime_reg;
                        prev_reg[0] <= so0;
                        prev_reg[1] <= so1;
                    end
                end
            end
        end
        p_reg   <= p_next;
        q_reg   <= q_next;
        inp_reg <= inp_next;
        inh_reg <= inh_next;
    end

    assign sem_out0 = 17'(so0);
    assign sem_out1 = 17'(so1);
    assign peak0    = peak_reg[0];
    assign peak1    = peak_reg[1];
endmodule
`default_nettype wire
